FILE: design/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sliding frame stacker: sample and
// register widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int FTS_W      = 5;
   localparam int FLEN_W     = 11;

   localparam logic [CSR_IDX_W-1:0] REG_FRAMES_TO_STACK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LENGTH    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_SIGNS    = 2'd2;

   localparam logic [FTS_W-1:0]  FTS_RESET  = 5'd1;
   localparam logic [FLEN_W-1:0] FLEN_RESET = 11'd1024;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_HOLD   = 4'b1000
   } state_type;

endpackage

FILE: design/sliding_frame_stacker.sv
// ----------------------------------------------------------------------------
// sliding_frame_stacker
// Coherent averaging of a framed sample stream over the last N frames, with
// optional alternating frame polarity, rounding and saturation.
//
//   port group  direction  carries
//   req_        in         sample word
//   rsp_        out        stacked average word, frame end flag
//   csr_        in         register index and write data
//
// A warm-up word, which gives no result, is only stored. A word that gives a
// result is summed with the same position of the earlier frames by N - 1
// frame-store reads, then the bit-serial divider forms the average; no new
// sample is taken until it is in the output register. Reset clears the
// counters and registers at once; the frame store needs no clearing pass. A
// finished word waits in the output register while the next sample is taken.
// ----------------------------------------------------------------------------
module sliding_frame_stacker #(
   parameter int MAX_FRAMES    = 16,
   parameter int MAX_FRAME_LEN = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [sfs_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [sfs_pkg::SAMPLE_W-1:0]   rsp_stacked,
   output logic                                  rsp_frame_end,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int SW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int PW    = (MAX_FRAME_LEN > 1) ? $clog2(MAX_FRAME_LEN) : 1;
   localparam int NW    = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W = 17 + $clog2(MAX_FRAMES);

   sfs_pkg::state_type state_ff, state_in;

   logic [sfs_pkg::FTS_W-1:0]  fts_ff, fts_in;
   logic [sfs_pkg::FLEN_W-1:0] flen_ff, flen_in;
   logic                       inv_ff, inv_in;

   logic [PW-1:0] pos_ff, pos_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [NW-1:0] seen_ff, seen_in;

   logic [PW-1:0]           item_pos_ff, item_pos_in;
   logic [SW-1:0]           rd_slot_ff, rd_slot_in;
   logic [NW-1:0]           issue_left_ff, issue_left_in;
   logic                    odd_ff, odd_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic                    rd_sub_ff, rd_sub_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic                    fend_ff, fend_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [sfs_pkg::SAMPLE_W-1:0] rsp_stacked_ff, rsp_stacked_in;
   logic                                rsp_frame_end_ff, rsp_frame_end_in;

   logic [NW-1:0] n_eff;
   logic [PW-1:0] len_m1;
   logic          csr_write, restart, accept, last, ready_item, out_free;
   logic          rd_en, div_start, div_done;
   logic signed [sfs_pkg::SAMPLE_W-1:0] rd_data, div_result;
   logic signed [SUM_W-1:0] rd_ext;

   always_comb begin
      if (fts_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(fts_ff) > MAX_FRAMES) begin
         n_eff = NW'(MAX_FRAMES);
      end else begin
         n_eff = NW'(fts_ff);
      end
      if (flen_ff == '0) begin
         len_m1 = '0;
      end else if (32'(flen_ff) > MAX_FRAME_LEN) begin
         len_m1 = PW'(MAX_FRAME_LEN - 1);
      end else begin
         len_m1 = PW'(flen_ff - sfs_pkg::FLEN_W'(1));
      end
   end

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign restart    = csr_write && (csr_index == sfs_pkg::REG_FRAMES_TO_STACK ||
                                     csr_index == sfs_pkg::REG_FRAME_LENGTH);
   assign req_ready  = (state_ff == sfs_pkg::ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign last       = (pos_ff == len_m1);
   assign ready_item = ((NW + 1)'(seen_ff) + (NW + 1)'(1)) >= (NW + 1)'(n_eff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rd_en      = (state_ff == sfs_pkg::ST_READ) && (issue_left_ff != '0);
   assign div_start  = (state_ff == sfs_pkg::ST_READ) && (issue_left_ff == '0) &&
                       !rd_valid_ff;
   assign rd_ext     = SUM_W'(rd_data);

   // registers
   always_comb begin
      fts_in  = fts_ff;
      flen_in = flen_ff;
      inv_in  = inv_ff;
      if (csr_write) begin
         case (csr_index)
            sfs_pkg::REG_FRAMES_TO_STACK: fts_in = csr_wdata[sfs_pkg::FTS_W-1:0];
            sfs_pkg::REG_FRAME_LENGTH:    flen_in = csr_wdata;
            sfs_pkg::REG_INVERT_SIGNS:    inv_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // frame counters
   always_comb begin
      pos_in  = pos_ff;
      slot_in = slot_ff;
      seen_in = seen_ff;
      if (restart) begin
         pos_in  = '0;
         slot_in = '0;
         seen_in = '0;
      end else if (accept) begin
         if (last) begin
            pos_in  = '0;
            slot_in = (slot_ff == SW'(MAX_FRAMES - 1)) ? '0 : slot_ff + SW'(1);
            if (seen_ff != NW'(MAX_FRAMES)) begin
               seen_in = seen_ff + NW'(1);
            end
         end else begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      item_pos_in      = item_pos_ff;
      rd_slot_in       = rd_slot_ff;
      issue_left_in    = issue_left_ff;
      odd_in           = odd_ff;
      rd_valid_in      = 1'b0;
      rd_sub_in        = rd_sub_ff;
      acc_in           = acc_ff;
      fend_in          = fend_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_stacked_in   = rsp_stacked_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      case (state_ff)
         sfs_pkg::ST_IDLE: begin
            if (accept && ready_item) begin
               state_in      = sfs_pkg::ST_READ;
               item_pos_in   = pos_ff;
               rd_slot_in    = (slot_ff == '0) ? SW'(MAX_FRAMES - 1) : slot_ff - SW'(1);
               issue_left_in = n_eff - NW'(1);
               odd_in        = 1'b1;
               acc_in        = SUM_W'(req_sample);
               fend_in       = last;
            end
         end
         sfs_pkg::ST_READ: begin
            if (rd_en) begin
               rd_valid_in   = 1'b1;
               rd_sub_in     = inv_ff && odd_ff;
               odd_in        = !odd_ff;
               issue_left_in = issue_left_ff - NW'(1);
               rd_slot_in    = (rd_slot_ff == '0) ? SW'(MAX_FRAMES - 1) :
                               rd_slot_ff - SW'(1);
            end
            if (rd_valid_ff) begin
               acc_in = rd_sub_ff ? acc_ff - rd_ext : acc_ff + rd_ext;
            end
            if (div_start) begin
               state_in = sfs_pkg::ST_DIVIDE;
            end
         end
         sfs_pkg::ST_DIVIDE, sfs_pkg::ST_HOLD: begin
            if (state_ff == sfs_pkg::ST_HOLD || div_done) begin
               if (out_free) begin
                  state_in         = sfs_pkg::ST_IDLE;
                  rsp_valid_in     = 1'b1;
                  rsp_stacked_in   = div_result;
                  rsp_frame_end_in = fend_ff;
               end else begin
                  state_in = sfs_pkg::ST_HOLD;
               end
            end
         end
         default: state_in = sfs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sfs_pkg::ST_IDLE;
         fts_ff        <= sfs_pkg::FTS_RESET;
         flen_ff       <= sfs_pkg::FLEN_RESET;
         inv_ff        <= 1'b0;
         pos_ff        <= '0;
         slot_ff       <= '0;
         seen_ff       <= '0;
         issue_left_ff <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fts_ff        <= fts_in;
         flen_ff       <= flen_in;
         inv_ff        <= inv_in;
         pos_ff        <= pos_in;
         slot_ff       <= slot_in;
         seen_ff       <= seen_in;
         issue_left_ff <= issue_left_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_pos_ff      <= item_pos_in;
      rd_slot_ff       <= rd_slot_in;
      odd_ff           <= odd_in;
      rd_sub_ff        <= rd_sub_in;
      acc_ff           <= acc_in;
      fend_ff          <= fend_in;
      rsp_stacked_ff   <= rsp_stacked_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   sfs_frame_mem #(
      .ADDR_W (SW + PW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr ({slot_ff, pos_ff}),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr ({rd_slot_ff, item_pos_ff}),
      .rd_data (rd_data)
   );

   sfs_divider #(
      .SUM_W (SUM_W),
      .N_W   (NW)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sum    (acc_ff),
      .n      (n_eff),
      .done   (div_done),
      .result (div_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_stacked   = rsp_stacked_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

`ifndef NO_ASSERTIONS
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == sfs_pkg::ST_DIVIDE)
      else $error("divider finished outside the divide phase");

   a_read_data_issued: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(rd_en))
      else $error("read data without a read");

   a_position_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && !last && !restart) |=> pos_ff == $past(pos_ff) + PW'(1))
      else $error("position did not advance");
`endif

endmodule

FILE: design/sfs_frame_mem.sv
// ----------------------------------------------------------------------------
// sfs_frame_mem
// Frame store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sfs_frame_mem #(
   parameter int ADDR_W = 14
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [ADDR_W-1:0]                   wr_addr,
   input  logic signed [sfs_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                                rd_en,
   input  logic [ADDR_W-1:0]                   rd_addr,
   output logic signed [sfs_pkg::SAMPLE_W-1:0] rd_data
);

   logic signed [sfs_pkg::SAMPLE_W-1:0] mem [0:(2**ADDR_W)-1];
   logic signed [sfs_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/sfs_divider.sv
// ----------------------------------------------------------------------------
// sfs_divider
// Bit-serial restoring divider: divides a signed sum by N, rounding half
// away from zero, and saturates the quotient to a signed sample.
// ----------------------------------------------------------------------------
module sfs_divider #(
   parameter int SUM_W = 21,
   parameter int N_W   = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [SUM_W-1:0]             sum,
   input  logic [N_W-1:0]                      n,
   output logic                                done,
   output logic signed [sfs_pkg::SAMPLE_W-1:0] result
);

   localparam int DIV_W = N_W + 1;
   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] num_ff, num_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [SUM_W-1:0] mag;
   logic [DIV_W:0]   trial;
   logic             q_bit;

   always_comb begin
      mag    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      trial  = {rem_ff, num_ff[SUM_W-1]};
      q_bit  = (trial >= {1'b0, dvs_ff});
      num_in = num_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = SUM_W'({mag, 1'b0}) + SUM_W'(n);
         rem_in  = '0;
         dvs_in  = {n, 1'b0};
         cnt_in  = CNT_W'(SUM_W);
         neg_in  = sum[SUM_W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = q_bit ? DIV_W'(trial - {1'b0, dvs_ff}) : DIV_W'(trial);
         num_in = {num_ff[SUM_W-2:0], q_bit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // saturate and restore the sign
   always_comb begin
      if (neg_ff) begin
         if (num_ff >= SUM_W'(32768)) begin
            result = sfs_pkg::SAMPLE_MIN;
         end else begin
            result = sfs_pkg::SAMPLE_W'(16'd0 - num_ff[sfs_pkg::SAMPLE_W-1:0]);
         end
      end else begin
         if (num_ff > SUM_W'(32767)) begin
            result = sfs_pkg::SAMPLE_MAX;
         end else begin
            result = num_ff[sfs_pkg::SAMPLE_W-1:0];
         end
      end
   end

   assign done = done_ff;

endmodule
